/* src/ccrc_pkg.sv */
`timescale 1ns / 1ps

package ccrc_pkg;

    localparam int CRC_W     = 32;
    localparam int BYTE_W    = 8;
    localparam int CFG_IDX_W = 2;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_POLYNOMIAL  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REFLECTED   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PRESET      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FINAL_XOR   = 2'd3;

    localparam logic [CRC_W-1:0] POLY_RESET   = 32'h04C1_1DB7;
    localparam logic [CRC_W-1:0] PRESET_RESET = 32'h0000_0000;
    localparam logic [CRC_W-1:0] XOR_RESET    = 32'h0000_0000;
    localparam logic [CRC_W-1:0] CRC_RESET    = 32'h0000_0000;

    localparam logic [BYTE_W-1:0] MSB_BYTE_MASK = 8'h80;
    localparam logic [BYTE_W-1:0] BYTE_MASK     = 8'hFF;

    typedef struct packed {
        logic [CRC_W-1:0] polynomial;
        logic             reflected_mode;
        logic [CRC_W-1:0] preset_value;
        logic [CRC_W-1:0] final_xor;
    } ccrc_cfg_t;

endpackage

/* src/ccrc_fold.sv */
`timescale 1ns / 1ps

module ccrc_fold (
    input  ccrc_pkg::ccrc_cfg_t         cfg,
    input  logic [ccrc_pkg::CRC_W-1:0]  crc_in,
    input  logic [ccrc_pkg::BYTE_W-1:0] data_byte,
    input  logic                        first_byte,
    input  logic                        last_byte,
    output logic [ccrc_pkg::CRC_W-1:0]  crc_out
);
    import ccrc_pkg::*;

    logic [CRC_W-1:0]  start;
    logic [CRC_W-1:0]  fwd;
    logic [CRC_W-1:0]  refl;
    logic [BYTE_W-1:0] mask;
    logic              fb;

    assign start = first_byte ? cfg.preset_value : crc_in;

    // eight unrolled shift steps for each bit order
    always_comb
    begin
        fwd  = start;
        mask = MSB_BYTE_MASK;
        for (int i = 0; i < BYTE_W; i++)
        begin
            fb   = fwd[CRC_W-1] ^ (|(data_byte & mask));
            fwd  = {fwd[CRC_W-2:0], 1'b0};
            if (fb)
            begin
                fwd = fwd ^ cfg.polynomial;
            end
            mask = mask >> 1;
        end
    end

    always_comb
    begin
        refl = start ^ {{(CRC_W-BYTE_W){1'b0}}, data_byte & BYTE_MASK};
        for (int i = 0; i < BYTE_W; i++)
        begin
            if (refl[0])
            begin
                refl = {1'b0, refl[CRC_W-1:1]} ^ cfg.polynomial;
            end
            else
            begin
                refl = {1'b0, refl[CRC_W-1:1]};
            end
        end
    end

    assign crc_out = (cfg.reflected_mode ? refl : fwd)
                   ^ (last_byte ? cfg.final_xor : {CRC_W{1'b0}});

endmodule

/* src/configurable_crc32_engine_unit.sv */
`timescale 1ns / 1ps

// byte-serial crc32 engine with programmable polynomial, bit order, preset
// and final xor
// input stream: s_axis_tdata carries one message byte, s_axis_tuser marks the
// first byte of a message (crc starts from the preset), s_axis_tlast marks the
// last byte (result gets the final xor)
// output stream: one transaction per input byte, m_axis_tdata is the running
// crc after that byte, m_axis_tlast says the final xor is included
// configuration: cfg_we writes cfg_data into register cfg_index
// (0 polynomial, 1 reflected mode, 2 preset, 3 final xor); write only while
// no byte is in flight
// pipeline: input register, then output register; one byte per cycle
// sustained while m_axis_tready is high, set by the combinational unrolled
// 8-bit update, whose result feeds the running crc register for the next byte
// reset: running crc clears to zero, registers return to their defaults
// (polynomial 0x04C11DB7, forward mode, preset and final xor zero), both
// pipeline stages empty
// stall: while m_axis_tready is low the result is held and one more byte
// can wait in the input register; s_axis_tready drops once both are full

module configurable_crc32_engine_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [7:0]                           s_axis_tdata,  // data_byte
    input  logic                                 s_axis_tuser,  // first_byte
    input  logic                                 s_axis_tlast,  // last_byte
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [ccrc_pkg::CRC_W-1:0]           m_axis_tdata,  // crc_value
    output logic                                 m_axis_tlast,  // is_final
    input  logic                                 cfg_we,
    input  logic [ccrc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ccrc_pkg::CRC_W-1:0]           cfg_data
);
    import ccrc_pkg::*;

    ccrc_cfg_t         cfg_reg;
    logic [CRC_W-1:0]  crc_reg;
    logic [CRC_W-1:0]  crc_next;

    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_data_reg;
    logic              in_first_reg;
    logic              in_last_reg;

    logic              out_valid_reg;
    logic [CRC_W-1:0]  out_crc_reg;
    logic              out_final_reg;

    logic              advance;

    // output register frees up when empty or taken this cycle
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.polynomial     <= POLY_RESET;
            cfg_reg.reflected_mode <= 1'b0;
            cfg_reg.preset_value   <= PRESET_RESET;
            cfg_reg.final_xor      <= XOR_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_POLYNOMIAL: cfg_reg.polynomial     <= cfg_data;
                REG_REFLECTED:  cfg_reg.reflected_mode <= cfg_data[0];
                REG_PRESET:     cfg_reg.preset_value   <= cfg_data;
                REG_FINAL_XOR:  cfg_reg.final_xor      <= cfg_data;
                default:        cfg_reg.polynomial     <= cfg_reg.polynomial;
            endcase
        end
    end

    ccrc_fold u_fold (
        .cfg        (cfg_reg),
        .crc_in     (crc_reg),
        .data_byte  (in_data_reg),
        .first_byte (in_first_reg),
        .last_byte  (in_last_reg),
        .crc_out    (crc_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            crc_reg       <= CRC_RESET;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                crc_reg       <= crc_next;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_data_reg  <= s_axis_tdata;
            in_first_reg <= s_axis_tuser;
            in_last_reg  <= s_axis_tlast;
        end
        if (advance)
        begin
            out_crc_reg   <= crc_next;
            out_final_reg <= in_last_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_crc_reg;
    assign m_axis_tlast  = out_final_reg;

endmodule
